// ===== rtl/tspr_pkg.sv =====
`default_nettype none
package tspr_pkg;
	localparam int NUM_SPRITES_DEF = 16;
	localparam int ROM_BYTES_DEF = 2048;
	localparam int SCREEN_WIDTH_DEF = 240;
	localparam int VRAM_BYTES = 1024;
	localparam logic [9:0] SPR_PIC_BASE = 10'h3c0;
	localparam logic [9:0] SPR_HPOS_BASE = 10'h3d0;
	localparam logic [9:0] SPR_VPOS_BASE = 10'h3e0;
	localparam logic [7:0] SPR_HIDE_ROW = 8'd248;

	typedef enum logic [1:0] {
		FUNC_WR_VRAM = 2'd0,
		FUNC_WR_ROM1 = 2'd1,
		FUNC_WR_ROM2 = 2'd2,
		FUNC_RENDER  = 2'd3
	} func_t;

	function automatic logic [7:0] palette_map(input logic [7:0] v);
		logic [7:0] r;
		unique case (v)
			8'd0: r = 8'h00;
			8'd1: r = 8'h07;
			8'd2: r = 8'h18;
			8'd3: r = 8'he0;
			default: r = v;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/tspr_if.sv =====
`default_nettype none
interface tspr_req_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [10:0] addr;
	logic [7:0] wdata;
	logic [7:0] px;
	logic [7:0] py;
	modport source(output valid, func, addr, wdata, px, py, input ready);
	modport sink(input valid, func, addr, wdata, px, py, output ready);
endinterface

interface tspr_pix_if;
	logic valid;
	logic ready;
	logic [7:0] pixel;
	modport source(output valid, pixel, input ready);
	modport sink(input valid, pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/tile_sprite_pixel_renderer.sv =====
// Tile/sprite pixel renderer. Writes (video RAM, ROM planes) complete on acceptance.
// For a render request the sequencer fetches the stamp code and then its ROM
// bytes (states ST_CODE and ST_ROM), then for each sprite reads its vertical
// position, horizontal position and picture register in turn through the
// single video RAM read port and the two ROM plane bytes at the picture
// address (states ST_VPOS, ST_HPOS, ST_PIC and ST_SROM), and applies the
// palette map in ST_DONE, where the result is registered. The last covering
// sprite wins. One request is in work at a time; the result sits in an
// output register, and the next request is taken once it is delivered.
// Video RAM writes at 1024 or above are dropped; columns at 240 and beyond
// render as 0.
`default_nettype none
module tile_sprite_pixel_renderer #(
	parameter int NUM_SPRITES = tspr_pkg::NUM_SPRITES_DEF
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  cfg_we,
	input  wire  cfg_wdata,
	tspr_req_if.sink   req,
	tspr_pix_if.source rsp
);
	localparam int SW = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_CODE  = 8'b00000010,
		ST_ROM   = 8'b00000100,
		ST_VPOS  = 8'b00001000,
		ST_HPOS  = 8'b00010000,
		ST_PIC   = 8'b00100000,
		ST_SROM  = 8'b01000000,
		ST_DONE  = 8'b10000000
	} state_t;

	state_t state_q;
	logic alt_q;
	logic [7:0] px_q, py_q, code_q, vpos_q, hpos_q, val_q, pix_q;
	logic [SW-1:0] idx_q;
	logic out_valid_q;
	logic wait_q;

	logic [9:0] vr_raddr;
	logic [10:0] rom_raddr;
	logic [7:0] vr_rdata, r1_rdata, r2_rdata;
	logic [2:0] bit_q;
	logic [1:0] extra_q;

	wire acc = req.valid && req.ready;
	wire wr_vr = acc && req.func == tspr_pkg::FUNC_WR_VRAM && !req.addr[10];
	wire wr_r1 = acc && req.func == tspr_pkg::FUNC_WR_ROM1;
	wire wr_r2 = acc && req.func == tspr_pkg::FUNC_WR_ROM2;
	wire [SW-1:0] idx_nx = idx_q + 1'b1;

	assign req.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.pixel = pix_q;

	tspr_ram #(.WIDTH(8), .DEPTH(tspr_pkg::VRAM_BYTES)) u_vram (
		.clk, .we(wr_vr), .waddr(req.addr[9:0]), .wdata(req.wdata),
		.raddr(vr_raddr), .rdata(vr_rdata));
	tspr_ram #(.WIDTH(8), .DEPTH(tspr_pkg::ROM_BYTES_DEF)) u_rom1 (
		.clk, .we(wr_r1), .waddr(req.addr), .wdata(req.wdata),
		.raddr(rom_raddr), .rdata(r1_rdata));
	tspr_ram #(.WIDTH(8), .DEPTH(tspr_pkg::ROM_BYTES_DEF)) u_rom2 (
		.clk, .we(wr_r2), .waddr(req.addr), .wdata(req.wdata),
		.raddr(rom_raddr), .rdata(r2_rdata));

	// sprite geometry from registered positions
	logic [7:0] v_pos, h_pos, dx, dy;
	logic sp_hit;
	logic [8:0] h_s;
	always_comb begin
		v_pos = 8'd247 - vpos_q;
		h_s = 9'd239 - {1'b0, hpos_q};
		h_pos = h_s[7:0];
		dx = px_q - h_pos;
		dy = py_q - v_pos;
		sp_hit = (v_pos < tspr_pkg::SPR_HIDE_ROW) && !h_s[8] &&
			(px_q >= h_pos) && (dx < 8'd16) && (py_q >= v_pos) && (dy < 8'd8);
	end

	// stamp address pieces
	logic [2:0] sx, sy, ssx, ssy;
	logic [4:0] col, row;
	logic [6:0] c;
	always_comb begin
		col = px_q[7:3];
		row = 5'd31 - py_q[7:3];
		sx = px_q[2:0];
		sy = py_q[2:0];
		if (!alt_q) begin
			ssx = vr_rdata[7] ? 3'd7 - sx : sx;
			ssy = vr_rdata[6] ? 3'd7 - sy : sy;
			c = {1'b0, vr_rdata[5:0]};
		end else begin
			ssx = sx;
			ssy = sy;
			c = {vr_rdata[6], vr_rdata[5:0]};
		end
	end

	logic [3:0] fsx;
	logic [2:0] fsy;
	always_comb begin
		fsx = vr_rdata[7] ? 4'd15 - dx[3:0] : dx[3:0];
		fsy = vr_rdata[6] ? 3'd7 - dy[2:0] : dy[2:0];
	end

	// video RAM address is issued in the state before the state that uses the data
	always_comb begin
		vr_raddr = {col, row};
		rom_raddr = {c[6], 1'b1, c[5:0], ssx};
		priority case (1'b1)
			state_q == ST_IDLE: vr_raddr = {req.px[7:3], 5'd31 - req.py[7:3]};
			state_q == ST_ROM: vr_raddr = tspr_pkg::SPR_VPOS_BASE + 10'(idx_q);
			state_q == ST_SROM: vr_raddr = tspr_pkg::SPR_VPOS_BASE + 10'(idx_nx);
			state_q == ST_VPOS: vr_raddr = tspr_pkg::SPR_HPOS_BASE + 10'(idx_q);
			state_q == ST_HPOS: vr_raddr = tspr_pkg::SPR_PIC_BASE + 10'(idx_q);
			default: vr_raddr = {col, row};
		endcase
		if (state_q == ST_PIC)
			rom_raddr = {vr_rdata[0], 1'b0, vr_rdata[5:1], fsx};
	end

	wire [7:0] rom_val = {6'd0, r2_rdata[bit_q], r1_rdata[bit_q]} | {4'd0, extra_q, 2'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			alt_q <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			wait_q <= 1'b0;
		end else begin
			if (cfg_we) alt_q <= cfg_wdata;
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (acc && req.func == tspr_pkg::FUNC_RENDER) begin
					px_q <= req.px;
					py_q <= req.py;
					state_q <= ST_CODE;
				end
				ST_CODE: begin
					bit_q <= ssy;
					extra_q <= alt_q ? vr_rdata[7:6] : 2'd0;
					idx_q <= '0;
					wait_q <= 1'b0;
					state_q <= ST_ROM;
				end
				ST_ROM: begin
					// ROM data now valid; VRAM fetching vpos of sprite 0
					val_q <= rom_val;
					state_q <= ST_VPOS;
				end
				ST_VPOS: begin
					vpos_q <= vr_rdata;
					state_q <= ST_HPOS;
				end
				ST_HPOS: begin
					hpos_q <= vr_rdata;
					state_q <= ST_PIC;
				end
				ST_PIC: begin
					bit_q <= fsy;
					extra_q <= 2'd0;
					wait_q <= sp_hit;
					state_q <= ST_SROM;
				end
				ST_SROM: begin
					if (!wait_q) begin
						if (wait_q == 1'b0 && idx_q == SW'(NUM_SPRITES - 1))
							state_q <= ST_DONE;
						else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_VPOS;
						end
					end else begin
						// ROM data of the covering sprite is now valid
						wait_q <= 1'b0;
						val_q <= rom_val;
						if (idx_q == SW'(NUM_SPRITES - 1)) state_q <= ST_DONE;
						else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_VPOS;
						end
					end
				end
				ST_DONE: begin
					pix_q <= (px_q >= 8'(tspr_pkg::SCREEN_WIDTH_DEF)) ? 8'd0 :
						tspr_pkg::palette_map(val_q);
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/tspr_ram.sv =====
`default_nettype none
module tspr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/tspr_checker.sv =====
`default_nettype none
module tspr_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire [7:0] out_pixel
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel))
		else $error("result dropped or changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while result pending");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result too soon after request");
endmodule

bind tile_sprite_pixel_renderer tspr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready), .out_pixel(rsp.pixel));
`default_nettype wire
